FILE: rtl/core/isd_pkg.sv
`default_nettype none

package isd_pkg;

   localparam int unsigned ISD_DEPTH = 64;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DESCENDING   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_REPEATS = 1'd1;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic      valid;
      value_type value;
      logic      desc;
   } carry_type;

   typedef struct packed {
      logic      full;
      value_type value;
   } slot_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

   function automatic logic goes_after(input value_type held, input value_type carry,
                                       input logic desc);
      goes_after = desc ? (held < carry) : (held > carry);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/isd_req_if.sv
`default_nettype none

interface isd_req_if;
   import isd_pkg::*;

   logic      valid;
   logic      ready;
   value_type value;
   logic      end_of_set;

   modport source (output valid, output value, output end_of_set, input ready);
   modport sink   (input valid, input value, input end_of_set, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/isd_rsp_if.sv
`default_nettype none

interface isd_rsp_if;
   import isd_pkg::*;

   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      run_end;
   logic      overflowed;

   modport source (output valid, output sorted_value, output run_end, output overflowed,
                   input ready);
   modport sink   (input valid, input sorted_value, input run_end, input overflowed,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/core/insertion_sorter_with_dedup_top.sv
// Channel  Dir  Transaction payload                      Handshake
// req_bus  in   value, end_of_set                        valid / ready
// rsp_bus  out  sorted_value, run_end, overflowed        valid / ready
// csr      in   csr_index, csr_wdata                     csr_we, no wait
//
// A value enters the cell row when accepted, unless DEPTH values are held; back-to-back
// values are taken while filling. After end_of_set the row settles while the last carry
// ripples through the cells, then drains one cell per cycle, unless stalled, via the hold
// register into the output register. rsp_ready low stalls the drain. Synchronous reset
// empties the row and clears the valid flags of the hold and output registers.
`default_nettype none

module insertion_sorter_with_dedup_top #(
   parameter int unsigned DEPTH = isd_pkg::ISD_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   isd_req_if.sink                              req_bus,
   isd_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [isd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [isd_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import isd_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            overflow_ff, overflow_in;
   logic            desc_ff, drop_ff;
   logic            hold_v_ff, hold_v_in;
   value_type       hold_ff, hold_in;
   logic            rsp_valid_ff, rsp_valid_in;
   value_type       rsp_value_ff, rsp_value_in;
   logic            rsp_end_ff, rsp_end_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   carry_type carries [DEPTH+1];
   slot_type  slots   [DEPTH+1];
   logic      shift;
   logic      carry_busy;
   logic      accept;
   logic      out_free;
   logic      dup;

   assign accept   = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign dup      = drop_ff && hold_v_ff && (slots[0].value == hold_ff);

   assign carries[0] = '{valid: accept && (count_ff < CNT_W'(DEPTH)),
                         value: req_bus.value, desc: desc_ff};
   assign slots[DEPTH] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      isd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .carry_in   (carries[g]),
         .carry_out  (carries[g+1]),
         .right_slot (slots[g+1]),
         .slot       (slots[g])
      );
   end

   always_comb begin
      carry_busy = 1'b0;
      for (int i = 1; i <= DEPTH; i++) begin
         carry_busy = carry_busy | carries[i].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
         drop_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DESCENDING:   desc_ff <= csr_wdata[0];
            CSR_DROP_REPEATS: drop_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      hold_v_in    = hold_v_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      shift        = 1'b0;
      req_bus.ready = (state_ff == ST_FILL);
      case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_bus.end_of_set) begin
                  state_in = ST_SETTLE;
               end
            end
         end
         ST_SETTLE: begin
            if (!carry_busy) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (slots[0].full) begin
               if (dup) begin
                  shift = 1'b1;
               end else if (!hold_v_ff) begin
                  shift     = 1'b1;
                  hold_v_in = 1'b1;
                  hold_in   = slots[0].value;
               end else if (out_free) begin
                  shift        = 1'b1;
                  hold_in      = slots[0].value;
                  rsp_valid_in = 1'b1;
                  rsp_value_in = hold_ff;
                  rsp_end_in   = 1'b0;
                  rsp_ovf_in   = overflow_ff;
               end
            end else if (!hold_v_ff) begin
               state_in    = ST_FILL;
               count_in    = '0;
               overflow_in = 1'b0;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = hold_ff;
               rsp_end_in   = 1'b1;
               rsp_ovf_in   = overflow_ff;
               hold_v_in    = 1'b0;
               state_in     = ST_FILL;
               count_in     = '0;
               overflow_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.sorted_value = rsp_value_ff;
   assign rsp_bus.run_end      = rsp_end_ff;
   assign rsp_bus.overflowed   = rsp_ovf_ff;

   a_drain_settled: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> !carry_busy)
      else $error("carry still in flight during drain");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("held count beyond depth");

   a_fill_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && count_ff == '0) |-> (!hold_v_ff && !slots[0].full))
      else $error("stale entry at start of set");

endmodule

`default_nettype wire

FILE: rtl/core/isd_cell.sv
`default_nettype none

module isd_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift,
   input  wire isd_pkg::carry_type carry_in,
   output isd_pkg::carry_type      carry_out,
   input  wire isd_pkg::slot_type  right_slot,
   output isd_pkg::slot_type       slot
);
   import isd_pkg::*;

   logic      full_ff,  full_in;
   value_type value_ff, value_in;
   carry_type carry_ff, carry_in_nxt;

   always_comb begin
      full_in      = full_ff;
      value_in     = value_ff;
      carry_in_nxt = '0;
      if (shift) begin
         full_in  = right_slot.full;
         value_in = right_slot.value;
      end else if (carry_in.valid) begin
         if (!full_ff) begin
            full_in  = 1'b1;
            value_in = carry_in.value;
         end else if (goes_after(value_ff, carry_in.value, carry_in.desc)) begin
            value_in     = carry_in.value;
            carry_in_nxt = '{valid: 1'b1, value: value_ff, desc: carry_in.desc};
         end else begin
            carry_in_nxt = carry_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= 1'b0;
         carry_ff <= '0;
      end else begin
         full_ff  <= full_in;
         carry_ff <= carry_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign carry_out = carry_ff;
   assign slot      = '{full: full_ff, value: value_ff};

endmodule

`default_nettype wire
